### src/htd_pkg.sv
// Shared types and constants for the Huffman tree decoder.
package htd_pkg;

    localparam int NODE_COUNT   = 512;
    localparam int MAX_CODE_LEN = 32;
    localparam int CODE_W       = 32;
    localparam int PTR_W        = $clog2(NODE_COUNT);
    localparam int USED_W       = $clog2(NODE_COUNT + 1);
    localparam int POS_W        = $clog2(MAX_CODE_LEN + 1);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_BRANCH = 2'd1;
    localparam logic [1:0] ERR_FULL   = 2'd2;
    localparam logic [1:0] ERR_LENGTH = 2'd3;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef struct packed {
        logic             leaf;
        logic [7:0]       sym;
        ptr_t [1:0]       child;
    } node_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [7:0]        code_symbol;
        logic [CODE_W-1:0] code_value;
        logic [5:0]        code_length;
        logic [7:0]        data_byte;
        logic [3:0]        valid_bits;
    } in_item_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       is_symbol;
        logic [1:0] error;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic  clear;
        logic  rd_en;
        ptr_t  rd_addr;
        logic  wr_en;
        ptr_t  wr_addr;
        node_t wr_data;
    } store_req_t;

endpackage

### src/htd_node_store.sv
// Node store: root node in flip-flops, all other nodes in a single-port-write RAM.
module htd_node_store (
    input  logic               aclk,
    input  logic               aresetn,
    input  htd_pkg::store_req_t req,
    output htd_pkg::node_t     rd_data,
    output htd_pkg::node_t     root_node
);
    import htd_pkg::*;

    node_t         mem [NODE_COUNT];
    node_t         rd_data_reg;
    ptr_t [1:0]    root_child_reg;

    always_comb begin
        root_node       = '0;
        root_node.child = root_child_reg;
    end

    // Entry zero of the RAM is never used; the root lives in registers.
    always_ff @(posedge aclk) begin
        if (req.wr_en && (req.wr_addr != '0)) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= (req.rd_addr == '0) ? root_node : mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || req.clear) begin
            root_child_reg <= '0;
        end else if (req.wr_en && (req.wr_addr == '0)) begin
            root_child_reg <= req.wr_data.child;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/huffman_tree_decoder.sv
// Huffman code tree builder and bit-serial decoder, top level.
//
// Items enter on s_item (s_valid/s_ready) and results leave on m_item
// (m_valid/m_ready). One item is worked on at a time; s_ready is high only
// between items. A clear item empties the tree and gives one status result.
// A load item walks the code path one node per step: an existing node is
// read from the node store in S_LD_READ and written back in S_LD_STEP, a
// new node is made in S_LD_STEP alone, and S_LD_LEAF writes the leaf. A
// decode item walks one bit per cycle through the node store, except while
// a held-back decoded symbol waits for the output register. Every result
// carries last on the final result of its item; a decode gives its symbols,
// and a status result when it decodes nothing or meets a missing branch.
// A decoded symbol is held back one step so that last can be set on it.
// The walk position carries over between decode items.
// Reset empties the tree (root without children) and returns the walk to
// the root; the node RAM needs no clearing. While m_ready is low, the block
// holds its output register and stops walking once it has another result.
module huffman_tree_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  htd_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output htd_pkg::out_item_t  m_item
);
    import htd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_LD_READ,
        S_LD_STEP,
        S_LD_LEAF,
        S_FLUSH
    } state_t;

    state_t            state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg, m_item_next;
    logic [USED_W-1:0] nodes_used_reg, nodes_used_next;
    ptr_t              walk_pos_reg, walk_pos_next;
    node_t             cur_rec_reg, cur_rec_next;
    ptr_t              cur_idx_reg, cur_idx_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CODE_W-1:0] code_val_reg, code_val_next;
    logic [7:0]        sym_reg, sym_next;
    ptr_t              leaf_idx_reg, leaf_idx_next;
    logic [7:0]        byte_reg, byte_next;
    logic [3:0]        bits_left_reg, bits_left_next;
    logic              chk_reg, chk_next;
    ptr_t              cand_reg, cand_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [7:0]        pend_sym_reg, pend_sym_next;
    logic [1:0]        fin_err_reg, fin_err_next;

    store_req_t req;
    node_t      rd_data;
    node_t      root_node;

    logic       out_free;
    logic       push;
    out_item_t  push_item;
    logic       leaf_hit;
    node_t      walk_cur;
    ptr_t       walk_nxt;
    logic       walk_bad;
    logic       walk_stall;
    logic       full;
    ptr_t       new_idx;
    logic       ld_bit;
    ptr_t       ld_nxt;
    logic       ld_bad;
    node_t      cur_mod;
    logic       len_bad;

    htd_node_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .rd_data   (rd_data),
        .root_node (root_node)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        // A leaf seen on the previous read sends the next bit back to the root.
        leaf_hit   = chk_reg && rd_data.leaf;
        walk_cur   = leaf_hit ? root_node : rd_data;
        walk_nxt   = walk_cur.child[byte_reg[7]];
        walk_bad   = (walk_nxt == '0) || (32'(walk_nxt) >= NODE_COUNT);
        walk_stall = leaf_hit && pend_valid_reg && !out_free;

        full    = (32'(nodes_used_reg) >= NODE_COUNT);
        new_idx = PTR_W'(nodes_used_reg);
        ld_bit  = (32'(pos_reg) < CODE_W) ? code_val_reg[5'(pos_reg)] : 1'b0;
        ld_nxt  = cur_rec_reg.child[ld_bit];
        ld_bad  = (ld_nxt == '0) || (32'(ld_nxt) >= NODE_COUNT);
        cur_mod = cur_rec_reg;
        cur_mod.child[ld_bit] = new_idx;
        len_bad = (s_item.code_length == '0) || (32'(s_item.code_length) > MAX_CODE_LEN);
    end

    always_comb begin
        state_next      = state_reg;
        nodes_used_next = nodes_used_reg;
        walk_pos_next   = walk_pos_reg;
        cur_rec_next    = cur_rec_reg;
        cur_idx_next    = cur_idx_reg;
        pos_next        = pos_reg;
        code_val_next   = code_val_reg;
        sym_next        = sym_reg;
        leaf_idx_next   = leaf_idx_reg;
        byte_next       = byte_reg;
        bits_left_next  = bits_left_reg;
        chk_next        = chk_reg;
        cand_next       = cand_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        fin_err_next    = fin_err_reg;
        req             = '0;
        push            = 1'b0;
        push_item       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_item.opcode)
                        OP_CLEAR: begin
                            req.clear       = 1'b1;
                            nodes_used_next = USED_W'(1);
                            walk_pos_next   = '0;
                            fin_err_next    = ERR_NONE;
                            state_next      = S_FLUSH;
                        end
                        OP_LOAD: begin
                            if (len_bad) begin
                                fin_err_next = ERR_LENGTH;
                                state_next   = S_FLUSH;
                            end else begin
                                req.rd_en     = 1'b1;
                                req.rd_addr   = '0;
                                cur_idx_next  = '0;
                                pos_next      = POS_W'(s_item.code_length - 6'd1);
                                code_val_next = s_item.code_value;
                                sym_next      = s_item.code_symbol;
                                state_next    = S_LD_READ;
                            end
                        end
                        OP_DECODE: begin
                            req.rd_en      = 1'b1;
                            req.rd_addr    = walk_pos_reg;
                            byte_next      = s_item.data_byte;
                            bits_left_next = (s_item.valid_bits > 4'd8) ? 4'd8
                                                                         : s_item.valid_bits;
                            chk_next       = 1'b0;
                            state_next     = S_WALK;
                        end
                        default: begin
                            fin_err_next = ERR_NONE;
                            state_next   = S_FLUSH;
                        end
                    endcase
                end
            end

            S_WALK: begin
                if (!walk_stall) begin
                    if (leaf_hit) begin
                        if (pend_valid_reg) begin
                            push      = 1'b1;
                            push_item = '{symbol: pend_sym_reg, is_symbol: 1'b1,
                                          error: ERR_NONE, last: 1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next   = rd_data.sym;
                        walk_pos_next   = '0;
                    end else if (chk_reg) begin
                        walk_pos_next = cand_reg;
                    end
                    chk_next = 1'b0;
                    if (bits_left_reg == '0) begin
                        fin_err_next = ERR_NONE;
                        state_next   = S_FLUSH;
                    end else if (walk_bad) begin
                        walk_pos_next = '0;
                        fin_err_next  = ERR_BRANCH;
                        state_next    = S_FLUSH;
                    end else begin
                        req.rd_en      = 1'b1;
                        req.rd_addr    = walk_nxt;
                        cand_next      = walk_nxt;
                        chk_next       = 1'b1;
                        byte_next      = {byte_reg[6:0], 1'b0};
                        bits_left_next = bits_left_reg - 4'd1;
                    end
                end
            end

            S_LD_READ: begin
                cur_rec_next = rd_data;
                state_next   = S_LD_STEP;
            end

            S_LD_STEP: begin
                // The current node is written back whenever the path leaves it.
                req.wr_en   = 1'b1;
                req.wr_addr = cur_idx_reg;
                req.wr_data = cur_rec_reg;
                if ((pos_reg != '0) && !ld_bad) begin
                    req.rd_en    = 1'b1;
                    req.rd_addr  = ld_nxt;
                    cur_idx_next = ld_nxt;
                    pos_next     = pos_reg - 1'b1;
                    state_next   = S_LD_READ;
                end else if (full) begin
                    fin_err_next = ERR_FULL;
                    state_next   = S_FLUSH;
                end else begin
                    req.wr_data     = cur_mod;
                    nodes_used_next = nodes_used_reg + 1'b1;
                    if (pos_reg != '0) begin
                        cur_rec_next = '0;
                        cur_idx_next = new_idx;
                        pos_next     = pos_reg - 1'b1;
                    end else begin
                        leaf_idx_next = new_idx;
                        state_next    = S_LD_LEAF;
                    end
                end
            end

            S_LD_LEAF: begin
                req.wr_en   = 1'b1;
                req.wr_addr = leaf_idx_reg;
                req.wr_data = '{leaf: 1'b1, sym: sym_reg, child: '0};
                fin_err_next = ERR_NONE;
                state_next   = S_FLUSH;
            end

            S_FLUSH: begin
                if (out_free) begin
                    push = 1'b1;
                    if (pend_valid_reg) begin
                        push_item = '{symbol: pend_sym_reg, is_symbol: 1'b1,
                                      error: ERR_NONE, last: (fin_err_reg == ERR_NONE)};
                        pend_valid_next = 1'b0;
                        if (fin_err_reg == ERR_NONE) begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        push_item  = '{symbol: 8'd0, is_symbol: 1'b0,
                                       error: fin_err_reg, last: 1'b1};
                        state_next = S_IDLE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next = push ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_item_next  = push ? push_item : m_item_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            nodes_used_reg <= USED_W'(1);
            walk_pos_reg   <= '0;
            chk_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            nodes_used_reg <= nodes_used_next;
            walk_pos_reg   <= walk_pos_next;
            chk_reg        <= chk_next;
            pend_valid_reg <= pend_valid_next;
        end
        m_item_reg    <= m_item_next;
        cur_rec_reg   <= cur_rec_next;
        cur_idx_reg   <= cur_idx_next;
        pos_reg       <= pos_next;
        code_val_reg  <= code_val_next;
        sym_reg       <= sym_next;
        leaf_idx_reg  <= leaf_idx_next;
        byte_reg      <= byte_next;
        bits_left_reg <= bits_left_next;
        cand_reg      <= cand_next;
        pend_sym_reg  <= pend_sym_next;
        fin_err_reg   <= fin_err_next;
    end

`ifndef SYNTHESIS
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!m_valid_reg || m_ready))
        else $error("result pushed over an unaccepted result");

    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !pend_valid_reg)
        else $error("item accepted while a symbol is still held back");

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(nodes_used_reg) <= NODE_COUNT) && (nodes_used_reg != '0))
        else $error("node count out of range");

    a_walk_allocated: assert property (@(posedge aclk) disable iff (!aresetn)
        USED_W'(walk_pos_reg) < nodes_used_reg)
        else $error("walk position points past the allocated nodes");
`endif

endmodule

### sim/testbench.sv
// Self-checking testbench for the Huffman tree decoder: tree building, decoding and error cases.
module testbench;
    import htd_pkg::*;

    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 80;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    huffman_tree_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Own copy of the code tree, kept in step with every accepted item.
    logic        tree_leaf [NODE_COUNT];
    logic [7:0]  tree_sym  [NODE_COUNT];
    ptr_t        tree_kid  [NODE_COUNT][2];
    int unsigned tree_used;
    ptr_t        walk_node;

    out_item_t   tree_results_due [$];
    out_item_t   want;

    int unsigned snd_idle_pct = 33;
    int unsigned rcv_idle_pct = 66;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned symbols_seen = 0;
    int unsigned errors_seen [4] = '{0, 0, 0, 0};
    int unsigned failures = 0;
    int unsigned cycle_count = 0;

    function automatic void empty_tree();
        tree_leaf[0]   = 1'b0;
        tree_sym[0]    = 8'd0;
        tree_kid[0][0] = '0;
        tree_kid[0][1] = '0;
        tree_used      = 1;
        walk_node      = '0;
    endfunction

    // Returns the new node, or zero when the store has no room left.
    function automatic ptr_t grow_node(input logic leaf, input logic [7:0] sym);
        ptr_t n;
        if (tree_used >= NODE_COUNT)
            return '0;
        n = ptr_t'(tree_used);
        tree_used++;
        tree_leaf[n]   = leaf;
        tree_sym[n]    = sym;
        tree_kid[n][0] = '0;
        tree_kid[n][1] = '0;
        return n;
    endfunction

    function automatic logic [1:0] insert_code(input logic [7:0] sym, input logic [31:0] value,
                                               input int unsigned len);
        ptr_t cur;
        ptr_t nxt;
        int   pos;
        logic b;
        cur = '0;
        if (len == 0 || len > MAX_CODE_LEN)
            return ERR_LENGTH;
        for (pos = int'(len) - 1; pos > 0; pos--) begin
            b   = value[pos];
            nxt = tree_kid[cur][b];
            if (nxt == '0) begin
                nxt = grow_node(1'b0, 8'd0);
                if (nxt == '0)
                    return ERR_FULL;
                tree_kid[cur][b] = nxt;
            end
            cur = nxt;
        end
        nxt = grow_node(1'b1, sym);
        if (nxt == '0)
            return ERR_FULL;
        tree_kid[cur][value[0]] = nxt;
        return ERR_NONE;
    endfunction

    function automatic void compute_tree_results(input in_item_t it);
        out_item_t status;
        out_item_t held;
        logic      held_valid;
        logic      stopped;
        logic      b;
        ptr_t      nxt;
        int        nb;
        int        i;
        status       = '0;
        status.last  = 1'b1;
        status.error = ERR_NONE;
        unique case (it.opcode)
            OP_CLEAR: begin
                empty_tree();
                tree_results_due.push_back(status);
            end
            OP_LOAD: begin
                status.error = insert_code(it.code_symbol, it.code_value, it.code_length);
                tree_results_due.push_back(status);
            end
            OP_DECODE: begin
                nb         = (it.valid_bits > 4'd8) ? 8 : int'(it.valid_bits);
                held       = '0;
                held_valid = 1'b0;
                stopped    = 1'b0;
                for (i = 0; i < nb && !stopped; i++) begin
                    b   = it.data_byte[7 - i];
                    nxt = tree_kid[walk_node][b];
                    if (nxt == '0) begin
                        walk_node = '0;
                        stopped   = 1'b1;
                    end else if (tree_leaf[nxt]) begin
                        // A symbol is only pushed once we know whether it ends the item.
                        if (held_valid)
                            tree_results_due.push_back(held);
                        held           = '0;
                        held.symbol    = tree_sym[nxt];
                        held.is_symbol = 1'b1;
                        held_valid     = 1'b1;
                        walk_node      = '0;
                    end else begin
                        walk_node = nxt;
                    end
                end
                if (stopped || !held_valid) begin
                    if (held_valid)
                        tree_results_due.push_back(held);
                    status.error = stopped ? ERR_BRANCH : ERR_NONE;
                    tree_results_due.push_back(status);
                end else begin
                    held.last = 1'b1;
                    tree_results_due.push_back(held);
                end
            end
            default: tree_results_due.push_back(status);
        endcase
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it.opcode      = 2'($urandom_range(3));
        it.code_symbol = 8'($urandom_range(255));
        it.code_value  = $urandom();
        it.code_length = 6'($urandom_range(63));
        it.data_byte   = 8'($urandom_range(255));
        it.valid_bits  = 4'($urandom_range(15));
        return it;
    endfunction

    // Valid stays high after acceptance when the next item follows at once;
    // it is lowered only when a gap or a wait comes next.
    task automatic send_item(input in_item_t it);
        if ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(99) < snd_idle_pct);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do
            @(posedge aclk);
        while (!s_ready);
        items_sent++;
        compute_tree_results(it);
    endtask

    task automatic send_clear();
        in_item_t it;
        it        = random_item();
        it.opcode = OP_CLEAR;
        send_item(it);
    endtask

    task automatic send_load(input logic [7:0] sym, input logic [31:0] value,
                             input int unsigned len);
        in_item_t it;
        it             = random_item();
        it.opcode      = OP_LOAD;
        it.code_symbol = sym;
        it.code_value  = value;
        it.code_length = 6'(len);
        send_item(it);
    endtask

    task automatic send_decode(input logic [7:0] data, input int unsigned nbits);
        in_item_t it;
        it            = random_item();
        it.opcode     = OP_DECODE;
        it.data_byte  = data;
        it.valid_bits = 4'(nbits);
        send_item(it);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tree_results_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_empty_tree();
        in_item_t it;
        send_decode(8'hFF, 8);
        it        = random_item();
        it.opcode = OP_UNUSED;
        send_item(it);
        send_decode(8'h00, 0);
        send_clear();
    endtask

    task automatic test_code_lengths();
        send_load(8'hFF, 32'hFFFF_FFFF, 0);
        send_load(8'hFF, 32'hFFFF_FFFF, MAX_CODE_LEN + 1);
        send_load(8'hFF, 32'hFFFF_FFFF, 63);
        send_load(8'hA5, 32'hFFFF_FFFF, MAX_CODE_LEN);
        send_load(8'h00, 32'h0000_0000, MAX_CODE_LEN);
        // The longest codes span four bytes, so the walk carries over.
        repeat (4) send_decode(8'hFF, 8);
        repeat (4) send_decode(8'h00, 8);
    endtask

    task automatic test_full_bytes();
        send_clear();
        send_load(8'h00, 32'd0, 1);
        send_load(8'hFF, 32'd1, 1);
        send_decode(8'hA5, 8);
        send_decode(8'h3C, 15);
        send_decode(8'hFF, 9);
        send_decode(8'h80, 3);
    endtask

    task automatic test_tree_quirks();
        send_clear();
        send_load(8'h11, 32'b0, 1);
        // This path runs through the leaf just made; decoding still stops there.
        send_load(8'h22, 32'b01, 2);
        send_decode(8'h40, 2);
        send_load(8'h33, 32'b1, 1);
        send_load(8'h44, 32'b1, 1);
        send_decode(8'h80, 1);
        send_load(8'h55, 32'b110, 3);
        send_decode(8'hC9, 8);
    endtask

    task automatic test_store_full();
        send_clear();
        while (tree_used < NODE_COUNT)
            send_load(8'($urandom_range(255)), $urandom(), MAX_CODE_LEN);
        send_load(8'h5A, 32'd0, 1);
        send_decode(8'($urandom_range(255)), 8);
        wait_for_results();
        send_clear();
    endtask

    task automatic test_random_traffic(input int unsigned n_items);
        logic [31:0] cv [$];
        int unsigned cl [$];
        logic [31:0] v;
        int unsigned l;
        int unsigned k;
        int unsigned max_len;
        int unsigned skip;
        int unsigned stop;
        stop = items_sent + n_items;
        while (items_sent < stop) begin
            if ($urandom_range(6) == 0) begin
                send_item(random_item());
            end else begin
                // Grow a complete prefix code by splitting leaves; a bias toward the
                // newest leaf makes long chains.
                cv      = {32'd0, 32'd1};
                cl      = {1, 1};
                max_len = ($urandom_range(7) == 0) ? MAX_CODE_LEN : 8;
                repeat ($urandom_range(14)) begin
                    k = ($urandom_range(3) == 0) ? cv.size() - 1 : $urandom_range(cv.size() - 1);
                    if (cl[k] < max_len) begin
                        v     = cv[k];
                        l     = cl[k];
                        cv[k] = v << 1;
                        cl[k] = l + 1;
                        cv.push_back((v << 1) | 32'd1);
                        cl.push_back(l + 1);
                    end
                end
                // Sometimes one code is left out so that decoding meets missing branches.
                skip = ($urandom_range(3) == 0) ? $urandom_range(cv.size() - 1) : cv.size();
                send_clear();
                for (k = 0; k < cv.size(); k++)
                    if (k != skip)
                        send_load(8'($urandom_range(255)), cv[k] | ($urandom() << cl[k]), cl[k]);
                repeat ($urandom_range(4, 20))
                    send_decode(8'($urandom_range(255)),
                                ($urandom_range(4) == 0) ? $urandom_range(15) : 8);
            end
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results still due", $time, tree_results_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (tree_results_due.size() == 0) begin
                failures++;
                $display("%0t: unexpected result sym=%02h is_sym=%0b err=%0d last=%0b",
                         $time, m_item.symbol, m_item.is_symbol, m_item.error, m_item.last);
            end else begin
                want = tree_results_due.pop_front();
                if (m_item.is_symbol)
                    symbols_seen++;
                errors_seen[m_item.error]++;
                if (m_item.symbol !== want.symbol || m_item.is_symbol !== want.is_symbol ||
                    m_item.error !== want.error || m_item.last !== want.last) begin
                    failures++;
                    $display("%0t: mismatch expected sym=%02h is_sym=%0b err=%0d last=%0b",
                             $time, want.symbol, want.is_symbol, want.error, want.last);
                    $display("%0t:          actual   sym=%02h is_sym=%0b err=%0d last=%0b",
                             $time, m_item.symbol, m_item.is_symbol, m_item.error,
                             m_item.last);
                end
            end
        end
    end

    initial begin
        empty_tree();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        snd_idle_pct = 33;
        rcv_idle_pct = 66;
        test_empty_tree();
        test_code_lengths();
        test_full_bytes();
        test_tree_quirks();
        test_store_full();
        test_random_traffic(45);
        wait_for_results();

        snd_idle_pct = 66;
        rcv_idle_pct = 33;
        test_random_traffic(45);
        wait_for_results();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_traffic(45);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d items and checked %0d results, %0d of them symbols.",
                 items_sent, results_seen, symbols_seen);
        $display("Errors seen: missing branch %0d, store full %0d, bad code length %0d.",
                 errors_seen[ERR_BRANCH], errors_seen[ERR_FULL], errors_seen[ERR_LENGTH]);
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
src/htd_pkg.sv
src/htd_node_store.sv
src/huffman_tree_decoder.sv
sim/testbench.sv
